[hw/rtl/window_3x3_line_buffer_assert.svh]
// Assertion shorthands, sampled on the rising clock edge and held off during reset.
`ifndef WINDOW_3X3_LINE_BUFFER_ASSERT_SVH
`define WINDOW_3X3_LINE_BUFFER_ASSERT_SVH

// Same-cycle implication.
`define W3LB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define W3LB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/w3lb_pkg.sv]
`timescale 1ns / 1ps

package w3lb_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_GROUPS = 16;
  localparam int GROUP_BITS = 32;

  localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int GRP_W     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int ROW_WORDS = MAX_WIDTH * MAX_GROUPS;
  localparam int ADDR_W    = COL_W + GRP_W;

  typedef logic [GROUP_BITS-1:0] word_t;

  // one column of the window, three rows of the same group
  typedef struct packed {
    word_t top;
    word_t mid;
    word_t bot;
  } col_t;

  localparam logic [2:0] REG_HEIGHT   = 3'd0;
  localparam logic [2:0] REG_WIDTH    = 3'd1;
  localparam logic [2:0] REG_GROUPS   = 3'd2;
  localparam logic [2:0] REG_STRIDE_V = 3'd3;
  localparam logic [2:0] REG_STRIDE_H = 3'd4;

  localparam logic [1:0] SLOT_0 = 2'd0;
  localparam logic [1:0] SLOT_1 = 2'd1;
  localparam logic [1:0] SLOT_2 = 2'd2;

endpackage

[hw/rtl/window_3x3_line_buffer.sv]
`timescale 1ns / 1ps

// 3x3 window former over a padded image streamed one channel-group word per transfer,
// in row, column, group order.
// Input channel: pixel_group with pixel_valid / pixel_ready. Output channel: tap0..tap8
// with window_valid / window_ready; taps are row-major, tap8 is the word that completed
// the window. One window per group is sent for every center on the stride grid.
// Registers height, width, channel_groups, stride_v, stride_h sit on the APB port at
// byte addresses 0x00..0x10; write them only while no transfer is in flight.
// Throughput: one input word per cycle while no waiting window stalls the input. The line store is three 4096-word
// RAMs, one per row slot, each with one write and one registered read per cycle, and
// a per-group history of the two previous window columns.
// The word that completes a window is registered in the middle stage, then the window in the output register.
// Reset clears all position counters and sets the registers to their defaults; line
// store contents are unknown until written, no clearing pass is run.
// When window_ready is low, the output register holds the window; input keeps flowing until a
// second window is waiting behind it, and the middle stage then holds that window's word.
module window_3x3_line_buffer (
  input  logic               clk,
  input  logic               rst,
  // APB configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // pixel stream
  input  logic               pixel_valid,
  output logic               pixel_ready,
  input  w3lb_pkg::word_t    pixel_group,
  // window stream
  output logic               window_valid,
  input  logic               window_ready,
  output w3lb_pkg::word_t    tap0,
  output w3lb_pkg::word_t    tap1,
  output w3lb_pkg::word_t    tap2,
  output w3lb_pkg::word_t    tap3,
  output w3lb_pkg::word_t    tap4,
  output w3lb_pkg::word_t    tap5,
  output w3lb_pkg::word_t    tap6,
  output w3lb_pkg::word_t    tap7,
  output w3lb_pkg::word_t    tap8
);

  import w3lb_pkg::*;

  // configuration registers
  logic [15:0] height;
  logic [8:0]  width;
  logic [4:0]  channel_groups;
  logic [3:0]  stride_v;
  logic [3:0]  stride_h;

  // position state
  logic [15:0]      in_row,     in_row_next;
  logic [COL_W-1:0] in_col,     in_col_next;
  logic [GRP_W-1:0] in_group,   in_group_next;
  logic [1:0]       write_slot, write_slot_next;
  logic [16:0]      center_row, center_row_next;
  logic [8:0]       center_col, center_col_next;

  logic [15:0] h_eff;
  logic [8:0]  w_eff;
  logic [4:0]  g_eff;
  logic        at_center, row_match, row_fits, col_fits, emit_now;
  logic        group_last, col_last, row_last;
  logic        pixel_fire, cfg_write;

  logic [ADDR_W-1:0] store_addr;
  word_t             rd_word [3];

  // middle stage
  logic             s1_valid;
  logic             s1_emit;
  logic             s1_adv;
  word_t            s1_word;
  logic [1:0]       s1_slot;
  logic [GRP_W-1:0] s1_grp;
  col_t             col_now;
  col_t             hist1 [MAX_GROUPS];
  col_t             hist2 [MAX_GROUPS];
  col_t             h1_rd, h2_rd;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign pixel_fire = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      height         <= 16'd10;
      width          <= 9'd10;
      channel_groups <= 5'd1;
      stride_v       <= 4'd1;
      stride_h       <= 4'd1;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_HEIGHT:   height         <= pwdata[15:0];
        REG_WIDTH:    width          <= pwdata[8:0];
        REG_GROUPS:   channel_groups <= pwdata[4:0];
        REG_STRIDE_V: stride_v       <= pwdata[3:0];
        REG_STRIDE_H: stride_h       <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_HEIGHT:   prdata = 32'(height);
      REG_WIDTH:    prdata = 32'(width);
      REG_GROUPS:   prdata = 32'(channel_groups);
      REG_STRIDE_V: prdata = 32'(stride_v);
      REG_STRIDE_H: prdata = 32'(stride_h);
      default:      prdata = 32'd0;
    endcase
  end

  // clamped limits
  always_comb begin
    h_eff = (height == 16'd0) ? 16'd1 : height;
    if (width == 9'd0)
      w_eff = 9'd1;
    else if (32'(width) > MAX_WIDTH)
      w_eff = 9'(MAX_WIDTH);
    else
      w_eff = width;
    if (channel_groups == 5'd0)
      g_eff = 5'd1;
    else if (32'(channel_groups) > MAX_GROUPS)
      g_eff = 5'(MAX_GROUPS);
    else
      g_eff = channel_groups;
  end

  always_comb begin
    row_match  = 18'(in_row) == 18'(center_row) + 18'd1;
    at_center  = row_match && (11'(in_col) == 11'(center_col) + 11'd1);
    row_fits   = 18'(center_row) + 18'd2 <= 18'(h_eff);
    col_fits   = 11'(center_col) + 11'd2 <= 11'(w_eff);
    emit_now   = at_center && row_fits && col_fits;
    group_last = 6'(in_group) + 6'd1 >= 6'(g_eff);
    col_last   = 13'(in_col) + 13'd1 >= 13'(w_eff);
    row_last   = 17'(in_row) + 17'd1 >= 17'(h_eff);
  end

  always_comb begin
    in_row_next     = in_row;
    in_col_next     = in_col;
    in_group_next   = in_group + GRP_W'(1);
    write_slot_next = write_slot;
    center_row_next = center_row;
    center_col_next = center_col;
    if (group_last) begin
      in_group_next = '0;
      if (at_center && col_fits)
        center_col_next = center_col + 9'(stride_h);
      if (col_last) begin
        in_col_next     = '0;
        center_col_next = 9'd1;
        if (row_match && row_fits)
          center_row_next = center_row + 17'(stride_v);
        write_slot_next = (write_slot == SLOT_2) ? SLOT_0 : write_slot + 2'd1;
        if (row_last) begin
          in_row_next     = '0;
          write_slot_next = SLOT_0;
          center_row_next = 17'd1;
        end else begin
          in_row_next = in_row + 16'd1;
        end
      end else begin
        in_col_next = in_col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row     <= '0;
      in_col     <= '0;
      in_group   <= '0;
      write_slot <= SLOT_0;
      center_row <= 17'd1;
      center_col <= 9'd1;
    end else if (pixel_fire) begin
      in_row     <= in_row_next;
      in_col     <= in_col_next;
      in_group   <= in_group_next;
      write_slot <= write_slot_next;
      center_row <= center_row_next;
      center_col <= center_col_next;
    end
  end

  // line store: one RAM per row slot, all read at the arriving word's column and group
  assign store_addr = {in_col, in_group};

  for (genvar s = 0; s < 3; s++) begin : g_slot
    word_t ram [ROW_WORDS];
    always_ff @(posedge clk) begin
      if (pixel_fire) begin
        if (write_slot == 2'(s))
          ram[store_addr] <= pixel_group;
        rd_word[s] <= ram[store_addr];
      end
    end
  end

  assign s1_adv      = s1_valid && (!s1_emit || !window_valid || window_ready);
  assign pixel_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst)
      s1_valid <= 1'b0;
    else if (pixel_fire)
      s1_valid <= 1'b1;
    else if (s1_adv)
      s1_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (pixel_fire) begin
      s1_emit <= emit_now;
      s1_word <= pixel_group;
      s1_slot <= write_slot;
      s1_grp  <= in_group;
    end
  end

  // column of the arriving word: two older rows from the store, bottom is the word
  always_comb begin
    col_now.bot = s1_word;
    case (s1_slot)
      SLOT_1: begin
        col_now.top = rd_word[2];
        col_now.mid = rd_word[0];
      end
      SLOT_2: begin
        col_now.top = rd_word[0];
        col_now.mid = rd_word[1];
      end
      default: begin
        col_now.top = rd_word[1];
        col_now.mid = rd_word[2];
      end
    endcase
  end

  assign h1_rd = hist1[s1_grp];
  assign h2_rd = hist2[s1_grp];

  // per-group history of the last two columns of the current row
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      hist2[s1_grp] <= h1_rd;
      hist1[s1_grp] <= col_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)
      window_valid <= 1'b0;
    else if (s1_adv && s1_emit)
      window_valid <= 1'b1;
    else if (window_ready)
      window_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      tap0 <= h2_rd.top;
      tap1 <= h1_rd.top;
      tap2 <= col_now.top;
      tap3 <= h2_rd.mid;
      tap4 <= h1_rd.mid;
      tap5 <= col_now.mid;
      tap6 <= h2_rd.bot;
      tap7 <= h1_rd.bot;
      tap8 <= col_now.bot;
    end
  end

`include "window_3x3_line_buffer_assert.svh"

  // a window needs two earlier columns and two earlier rows of history
  `W3LB_ASSERT_NOW(a_emit_has_history, pixel_fire && emit_now, (in_col >= COL_W'(2)) && (in_row >= 16'd2), "window requested without history")
  // a waiting window blocks the next one and the input behind it
  `W3LB_ASSERT_NOW(a_no_overwrite, s1_valid && s1_emit && window_valid && !window_ready, !pixel_ready && !s1_adv, "pending window would be overwritten")
  // last word of an image rewinds row state
  `W3LB_ASSERT_NEXT(a_image_rewind, pixel_fire && group_last && col_last && row_last, (in_row == 16'd0) && (write_slot == SLOT_0) && (center_row == 17'd1), "image end did not rewind")

endmodule
